// ===== rtl/core/hsm_pkg.sv =====
// hsm_pkg: shared sizes, request codes, bucket row layout and bucket hash
// for the hash set membership unit; depends on nothing
package hsm_pkg;

  localparam int NUM_BUCKETS = 1024;
  localparam int WAYS        = 4;
  localparam int KEY_W       = 32;
  localparam int BUCKET_W    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int WAY_W       = (WAYS > 1) ? $clog2(WAYS) : 1;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_TEST   = 2'd1,
    REQ_DELETE = 2'd2
  } req_type_t;

  typedef struct packed {
    logic [WAYS-1:0]            valid;
    logic [WAYS-1:0][KEY_W-1:0] key;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  // low bits of |key|: the low bits of a negation depend only on the low bits
  function automatic logic [BUCKET_W-1:0] bucket_of(input logic [KEY_W-1:0] key);
    logic [BUCKET_W-1:0] low;
    low = key[BUCKET_W-1:0];
    return key[KEY_W-1] ? (~low + BUCKET_W'(1)) : low;
  endfunction

endpackage

// ===== rtl/core/hsm_ifs.sv =====
// hsm_ifs: valid/ready channel interfaces for request and result items
// depends on hsm_pkg
interface hsm_req_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     req_type;
  logic signed [hsm_pkg::KEY_W-1:0] item_key;

  modport source (output valid, output req_type, output item_key, input ready);
  modport sink   (input valid, input req_type, input item_key, output ready);
endinterface

interface hsm_rsp_if;
  logic valid;
  logic ready;
  logic was_present;
  logic bucket_full;

  modport source (output valid, output was_present, output bucket_full, input ready);
  modport sink   (input valid, input was_present, input bucket_full, output ready);
endinterface

// ===== rtl/core/hsm_ram.sv =====
// hsm_ram: generic single-write, single-read memory with registered read
// depends on nothing
module hsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/hash_set_membership_unit.sv =====
// hash_set_membership_unit: hash set of signed keys, fixed ways per bucket
// depends on hsm_pkg, hsm_ifs and hsm_ram
// result: an accepted item moves to ST_LOOKUP, which then loads the result register
// a new item is taken only in ST_IDLE, after the read then write back of the last bucket row
// reset: rows are cleared one per cycle, all NUM_BUCKETS (1024) rows, with in ready low
// the result register lets a new item in on the cycle its result is taken
module hash_set_membership_unit (
  input  logic       clk,
  input  logic       rst_n,
  hsm_req_if.sink    in_chan,
  hsm_rsp_if.source  out_chan
);

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_LOOKUP} st_t;

  st_t                           state_r;
  logic [hsm_pkg::BUCKET_W-1:0]  clr_cnt_r;
  logic [hsm_pkg::BUCKET_W-1:0]  bucket_r;
  logic [hsm_pkg::KEY_W-1:0]     key_r;
  logic [1:0]                    op_r;
  logic                          out_valid_r;
  logic                          was_present_r;
  logic                          bucket_full_r;

  logic                          in_acc;
  logic                          ram_we;
  logic [hsm_pkg::BUCKET_W-1:0]  ram_waddr;
  hsm_pkg::row_t                 ram_wdata;
  logic [hsm_pkg::BUCKET_W-1:0]  ram_raddr;
  hsm_pkg::row_t                 rd_row;
  logic [hsm_pkg::ROW_W-1:0]     rd_bits;

  logic                          hit;
  logic [hsm_pkg::WAY_W-1:0]     hit_way;
  logic                          free;
  logic [hsm_pkg::WAY_W-1:0]     free_way;
  hsm_pkg::row_t                 row_nxt;
  logic                          row_we;
  logic                          full;

  assign in_chan.ready = (state_r == ST_IDLE) && (!out_valid_r || out_chan.ready);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign ram_raddr     = hsm_pkg::bucket_of(in_chan.item_key);
  assign rd_row        = hsm_pkg::row_t'(rd_bits);

  hsm_ram #(
    .WIDTH (hsm_pkg::ROW_W),
    .DEPTH (hsm_pkg::NUM_BUCKETS)
  ) u_row_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_acc),
    .raddr (ram_raddr),
    .rdata (rd_bits)
  );

  // way match and lowest free way
  always_comb begin
    hit      = 1'b0;
    hit_way  = '0;
    free     = 1'b0;
    free_way = '0;
    for (int w = 0; w < hsm_pkg::WAYS; w++) begin
      if (rd_row.valid[w]) begin
        if (!hit && rd_row.key[w] == key_r) begin
          hit     = 1'b1;
          hit_way = hsm_pkg::WAY_W'(w);
        end
      end else if (!free) begin
        free     = 1'b1;
        free_way = hsm_pkg::WAY_W'(w);
      end
    end
  end

  always_comb begin
    row_nxt = rd_row;
    row_we  = 1'b0;
    full    = 1'b0;
    unique case (op_r)
      hsm_pkg::REQ_INSERT: begin
        if (!hit) begin
          if (free) begin
            row_nxt.valid[free_way] = 1'b1;
            row_nxt.key[free_way]   = key_r;
            row_we                  = 1'b1;
          end else begin
            full = 1'b1;
          end
        end
      end
      hsm_pkg::REQ_DELETE: begin
        if (hit) begin
          row_nxt.valid[hit_way] = 1'b0;
          row_we                 = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = bucket_r;
    ram_wdata = row_nxt;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        ram_wdata = '0;
      end
      ST_LOOKUP: begin
        ram_we = row_we;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_chan.ready && state_r != ST_LOOKUP) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + hsm_pkg::BUCKET_W'(1);
          if (clr_cnt_r == hsm_pkg::BUCKET_W'(hsm_pkg::NUM_BUCKETS - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            state_r <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          out_valid_r   <= 1'b1;
          was_present_r <= hit;
          bucket_full_r <= full;
          state_r       <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      bucket_r <= ram_raddr;
      key_r    <= in_chan.item_key;
      op_r     <= in_chan.req_type;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.was_present = was_present_r;
  assign out_chan.bucket_full = bucket_full_r;

`ifndef SYNTHESIS
  a_full_not_present: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(was_present_r && bucket_full_r))
    else $error("dropped insert reported as present");

  a_full_only_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && bucket_full_r) |-> (op_r == hsm_pkg::REQ_INSERT))
    else $error("bucket full on a non-insert item");

  a_lookup_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOOKUP) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("lookup did not produce a result");

  a_accept_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_LOOKUP && !out_valid_r))
    else $error("accepted item not looked up with free result slot");
`endif

endmodule
